### src/yuvpl_pkg.sv
// ----------------------------------------------------------------------------
// yuvpl_pkg: shared types and constants for the YUV plane layout block
// Format codes, frame size classes and the records passed between stages.
// ----------------------------------------------------------------------------
package yuvpl_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;

  typedef enum logic [3:0] {
    F_YV12 = 4'd0,
    F_IF09 = 4'd1,
    F_YVU9 = 4'd2,
    F_IYUV = 4'd3,
    F_Y42B = 4'd4,
    F_I420 = 4'd5,
    F_YV16 = 4'd6,
    F_YV24 = 4'd7,
    F_Y41B = 4'd8,
    F_UYVY = 4'd9,
    F_YUY2 = 4'd10,
    F_YVYU = 4'd11,
    F_HDYC = 4'd12
  } fmt_t;

  // How the frame size follows from the pixel count.
  typedef enum logic [2:0] {
    SZ_NONE,
    SZ_X2,
    SZ_X3H,
    SZ_X9E,
    SZ_X3
  } size_cls_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [3:0]       format;
  } req_t;

  // Decoded request, output of the first stage.
  typedef struct packed {
    logic             ok;
    size_cls_t        sz;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [1:0]       yps;
    logic [13:0]      yls;
    logic [DIM_W-1:0] cw;
    logic [DIM_W-1:0] ch;
    logic [2:0]       cps;
    logic [13:0]      cls;
    logic             packed_fmt;
    logic             u_first;
    logic             yo;
    logic [1:0]       pk_uo;
    logic [1:0]       pk_vo;
  } dec_t;

  // Products, output of the second stage.
  typedef struct packed {
    logic             ok;
    size_cls_t        sz;
    logic [24:0]      area;
    logic [25:0]      plane;
    logic [25:0]      cplane;
    logic [1:0]       yps;
    logic [13:0]      yls;
    logic [DIM_W-1:0] cw;
    logic [DIM_W-1:0] ch;
    logic [2:0]       cps;
    logic [13:0]      cls;
    logic             packed_fmt;
    logic             u_first;
    logic             yo;
    logic [1:0]       pk_uo;
    logic [1:0]       pk_vo;
  } prod_t;

  typedef struct packed {
    logic             layout_valid;
    logic [25:0]      frame_bytes;
    logic [1:0]       luma_pixel_stride;
    logic [13:0]      luma_line_stride;
    logic [DIM_W-1:0] chroma_width;
    logic [DIM_W-1:0] chroma_height;
    logic [2:0]       chroma_pixel_stride;
    logic [13:0]      chroma_line_stride;
    logic             luma_offset;
    logic [25:0]      cb_offset;
    logic [25:0]      cr_offset;
  } layout_t;

endpackage

### src/yuvpl_if.sv
// ----------------------------------------------------------------------------
// yuvpl_if: request and result channels of the YUV plane layout block
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface yuvpl_req_if import yuvpl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;
  logic [3:0]       format;

  modport source (output valid, width, height, format, input ready);
  modport sink   (input valid, width, height, format, output ready);
endinterface

interface yuvpl_rsp_if import yuvpl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             layout_valid;
  logic [25:0]      frame_bytes;
  logic [1:0]       luma_pixel_stride;
  logic [13:0]      luma_line_stride;
  logic [DIM_W-1:0] chroma_width;
  logic [DIM_W-1:0] chroma_height;
  logic [2:0]       chroma_pixel_stride;
  logic [13:0]      chroma_line_stride;
  logic             luma_offset;
  logic [25:0]      cb_offset;
  logic [25:0]      cr_offset;

  modport source (output valid, layout_valid, frame_bytes, luma_pixel_stride,
                  luma_line_stride, chroma_width, chroma_height,
                  chroma_pixel_stride, chroma_line_stride, luma_offset,
                  cb_offset, cr_offset, input ready);
  modport sink   (input valid, layout_valid, frame_bytes, luma_pixel_stride,
                  luma_line_stride, chroma_width, chroma_height,
                  chroma_pixel_stride, chroma_line_stride, luma_offset,
                  cb_offset, cr_offset, output ready);
endinterface

### src/yuvpl_decode.sv
// ----------------------------------------------------------------------------
// yuvpl_decode: first pipeline stage
// Checks the request, picks subsampling and strides for the format.
// ----------------------------------------------------------------------------
module yuvpl_decode import yuvpl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output dec_t out_data
);

  dec_t d;
  logic in_range;
  logic div_ok;
  logic known;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;

  assign w = in_data.width;
  assign h = in_data.height;
  assign in_range = (w <= DIM_W'(MAX_DIM)) && (h <= DIM_W'(MAX_DIM));

  always_comb begin
    d            = '0;
    d.width      = w;
    d.height     = h;
    d.yps        = 2'd1;
    d.yls        = {1'b0, w};
    d.cw         = w;
    d.ch         = h;
    d.cps        = 3'd1;
    d.cls        = {1'b0, w};
    d.sz         = SZ_X3;
    div_ok       = 1'b1;
    known        = 1'b1;
    case (in_data.format)
      F_UYVY, F_YUY2, F_YVYU, F_HDYC: begin
        div_ok       = ~w[0];
        d.yps        = 2'd2;
        d.yls        = {w, 1'b0};
        d.cw         = {1'b0, w[DIM_W-1:1]};
        d.cps        = 3'd4;
        d.cls        = {w, 1'b0};
        d.sz         = SZ_X2;
        d.packed_fmt = 1'b1;
        case (in_data.format)
          F_YUY2: begin
            d.yo = 1'b0; d.pk_uo = 2'd1; d.pk_vo = 2'd3;
          end
          F_YVYU: begin
            d.yo = 1'b0; d.pk_uo = 2'd3; d.pk_vo = 2'd1;
          end
          default: begin
            d.yo = 1'b1; d.pk_uo = 2'd0; d.pk_vo = 2'd2;
          end
        endcase
      end
      F_YV12, F_IYUV, F_I420: begin
        div_ok    = ~w[0] & ~h[0];
        d.cw      = {1'b0, w[DIM_W-1:1]};
        d.ch      = {1'b0, h[DIM_W-1:1]};
        d.cls     = {2'b0, w[DIM_W-1:1]};
        d.sz      = SZ_X3H;
        d.u_first = (in_data.format != F_YV12);
      end
      F_IF09, F_YVU9: begin
        div_ok = (w[1:0] == 2'b00) && (h[1:0] == 2'b00);
        d.cw   = {2'b0, w[DIM_W-1:2]};
        d.ch   = {2'b0, h[DIM_W-1:2]};
        d.cls  = {3'b0, w[DIM_W-1:2]};
        d.sz   = SZ_X9E;
      end
      F_Y42B, F_YV16: begin
        div_ok    = ~w[0];
        d.cw      = {1'b0, w[DIM_W-1:1]};
        d.cls     = {2'b0, w[DIM_W-1:1]};
        d.sz      = SZ_X2;
        d.u_first = (in_data.format == F_Y42B);
      end
      F_Y41B: begin
        div_ok    = (w[1:0] == 2'b00);
        d.cw      = {2'b0, w[DIM_W-1:2]};
        d.cls     = {3'b0, w[DIM_W-1:2]};
        d.sz      = SZ_X3H;
        d.u_first = 1'b1;
      end
      F_YV24: begin
        d.sz = SZ_X3;
      end
      default: begin
        known = 1'b0;
        d.sz  = SZ_NONE;
      end
    endcase
    // Out-of-range requests report nothing at all, frame size included.
    if (!in_range) begin
      d.sz = SZ_NONE;
    end
    d.ok = in_range && known && div_ok && (w != '0) && (h != '0);
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= d;
    end
  end

endmodule

### src/yuvpl_mult.sv
// ----------------------------------------------------------------------------
// yuvpl_mult: second pipeline stage
// Forms the pixel count and the luma and chroma plane sizes.
// ----------------------------------------------------------------------------
module yuvpl_mult import yuvpl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  dec_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t out_data
);

  prod_t p;
  logic [25:0] area_full;
  logic [26:0] plane_full;
  logic [26:0] cplane_full;

  assign area_full   = 26'(in_data.width) * 26'(in_data.height);
  assign plane_full  = 27'(in_data.yls) * 27'(in_data.height);
  assign cplane_full = 27'(in_data.cls) * 27'(in_data.ch);

  always_comb begin
    p            = '0;
    p.ok         = in_data.ok;
    p.sz         = in_data.sz;
    p.area       = area_full[24:0];
    p.plane      = plane_full[25:0];
    p.cplane     = cplane_full[25:0];
    p.yps        = in_data.yps;
    p.yls        = in_data.yls;
    p.cw         = in_data.cw;
    p.ch         = in_data.ch;
    p.cps        = in_data.cps;
    p.cls        = in_data.cls;
    p.packed_fmt = in_data.packed_fmt;
    p.u_first    = in_data.u_first;
    p.yo         = in_data.yo;
    p.pk_uo      = in_data.pk_uo;
    p.pk_vo      = in_data.pk_vo;
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= p;
    end
  end

endmodule

### src/yuvpl_sum.sv
// ----------------------------------------------------------------------------
// yuvpl_sum: third pipeline stage and output register
// Scales the pixel count to a frame size and places the chroma planes.
// ----------------------------------------------------------------------------
module yuvpl_sum import yuvpl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  prod_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output layout_t out_data
);

  layout_t r;
  logic [26:0] a;
  logic [26:0] fb;
  logic [26:0] both;

  assign a    = 27'(in_data.area);
  assign both = 27'(in_data.plane) + 27'(in_data.cplane);

  always_comb begin
    case (in_data.sz)
      SZ_X2:   fb = a << 1;
      SZ_X3H:  fb = a + (a >> 1);
      SZ_X9E:  fb = a + (a >> 3);
      SZ_X3:   fb = a + (a << 1);
      default: fb = '0;
    endcase
  end

  always_comb begin
    r             = '0;
    r.frame_bytes = fb[25:0];
    if (in_data.ok) begin
      r.layout_valid        = 1'b1;
      r.luma_pixel_stride   = in_data.yps;
      r.luma_line_stride    = in_data.yls;
      r.chroma_width        = in_data.cw;
      r.chroma_height       = in_data.ch;
      r.chroma_pixel_stride = in_data.cps;
      r.chroma_line_stride  = in_data.cls;
      r.luma_offset         = in_data.yo;
      if (in_data.packed_fmt) begin
        r.cb_offset = 26'(in_data.pk_uo);
        r.cr_offset = 26'(in_data.pk_vo);
      end else if (in_data.u_first) begin
        r.cb_offset = in_data.plane;
        r.cr_offset = both[25:0];
      end else begin
        r.cr_offset = in_data.plane;
        r.cb_offset = both[25:0];
      end
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= r;
    end
  end

endmodule

### src/yuv_plane_layout.sv
// ----------------------------------------------------------------------------
// yuv_plane_layout: memory layout of one YUV frame
// Three-stage pipeline from frame size and FOURCC code to strides and offsets.
// ----------------------------------------------------------------------------
// Each request beat carries a frame width, a frame height and a format code
// (YV12, IF09, YVU9, IYUV, Y42B, I420, YV16, YV24, Y41B, UYVY, YUY2, YVYU,
// HDYC); each one yields exactly one result beat, in order. The block
// takes one request per cycle while the result side is ready: the three
// stages (decode, multiply, sum) each hold one beat, and each stage
// advances whenever its successor is empty or being drained, so a held
// result only stalls the stages behind it. Each stage ends in a register;
// the middle stage holds the three multipliers (pixel count and the two
// plane sizes), which work combinationally between the decode and
// multiply registers. A result whose layout_valid is clear has every
// stride and offset at zero; frame_bytes still reports the size for a
// known format, and is zero for an unknown code or an oversized dimension.
module yuv_plane_layout import yuvpl_pkg::*; (
  input  logic clk,
  input  logic rst,
  yuvpl_req_if.sink   req,
  yuvpl_rsp_if.source rsp
);

  req_t    req_data;
  dec_t    dec_data;
  prod_t   prod_data;
  layout_t rsp_data;
  logic    dec_valid;
  logic    dec_ready;
  logic    prod_valid;
  logic    prod_ready;

  assign req_data.width  = req.width;
  assign req_data.height = req.height;
  assign req_data.format = req.format;

  // Stage one: format decode, range and divisibility checks.
  yuvpl_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (req_data),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  // Stage two: pixel count and plane sizes.
  yuvpl_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  // Stage three: frame size, plane offsets; its register drives the result.
  yuvpl_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

  assign rsp.layout_valid        = rsp_data.layout_valid;
  assign rsp.frame_bytes         = rsp_data.frame_bytes;
  assign rsp.luma_pixel_stride   = rsp_data.luma_pixel_stride;
  assign rsp.luma_line_stride    = rsp_data.luma_line_stride;
  assign rsp.chroma_width        = rsp_data.chroma_width;
  assign rsp.chroma_height       = rsp_data.chroma_height;
  assign rsp.chroma_pixel_stride = rsp_data.chroma_pixel_stride;
  assign rsp.chroma_line_stride  = rsp_data.chroma_line_stride;
  assign rsp.luma_offset         = rsp_data.luma_offset;
  assign rsp.cb_offset           = rsp_data.cb_offset;
  assign rsp.cr_offset           = rsp_data.cr_offset;

endmodule

### tb/yuv_plane_layout_test.sv
// ----------------------------------------------------------------------------
// yuv_plane_layout_test: self-checking bench for the YUV plane layout block
// Feeds frame-size and FOURCC requests through the request channel, predicts
// every layout record on the side, and compares each result beat field by
// field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module yuv_plane_layout_test;
  import yuvpl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The directed part is 26 beats; the random part follows it.
  localparam int RANDOM_BEATS = 1150;
  localparam int TOTAL_BEATS  = 26 + RANDOM_BEATS;
  // No idling on either side over the last stretch of the run.
  localparam int TAIL_BEATS   = 150;
  // The sender never pauses while request numbers fall in this window, so
  // the long receiver hold-off below really backs the pipeline up.
  localparam int BUSY_FIRST   = 500;
  localparam int BUSY_LAST    = 800;
  // The receiver holds off once, after this many results, for this long.
  localparam int HOLD_AT      = 560;
  localparam int HOLD_CYCLES  = 200;
  // The receiver runs without stalls while this many results have arrived.
  localparam int STEADY_FIRST = 300;
  localparam int STEADY_LAST  = 450;

  // A queued request together with the idle cycles the sender spends
  // before offering it.
  typedef struct packed {
    logic [3:0] gap;
    req_t       req;
  } req_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  yuvpl_req_if req_ch ();
  yuvpl_rsp_if rsp_ch ();

  yuv_plane_layout DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  req_beat_t layout_requests[$];
  layout_t   expected_layouts[$];
  int        beats_queued    = 0;
  int        layouts_checked = 0;
  int        mismatch_count  = 0;

  // Computes the layout record that a request must produce. Sizes are worked
  // out at 64 bits and then cut to the width of each result field.
  function automatic layout_t predict_layout(req_t rq);
    layout_t         lo;
    logic [3:0]      f;
    longint unsigned w, h, area, bytes;
    longint unsigned yps, yls, cw, ch, cps, cls;
    longint unsigned plane, cplane, yo, uo, vo;
    bit              ok;

    lo = '0;
    w  = rq.width;
    h  = rq.height;
    f  = rq.format;
    // A dimension above the maximum gives an all-zero record, size included.
    if (w > MAX_DIM || h > MAX_DIM) return lo;

    area = w * h;
    case (f)
      F_UYVY, F_YUY2, F_YVYU, F_HDYC, F_Y42B, F_YV16: bytes = area * 2;
      F_YV12, F_IYUV, F_I420, F_Y41B:                 bytes = area * 3 / 2;
      F_IF09, F_YVU9:                                 bytes = area * 9 / 8;
      F_YV24:                                         bytes = area * 3;
      default:                                        bytes = 0;
    endcase
    // The size is reported even when the layout itself is refused.
    lo.frame_bytes = bytes[25:0];

    ok  = (w != 0) && (h != 0) && (f <= F_HDYC);
    yps = (f >= F_UYVY) ? 2 : 1;
    yls = w * yps;
    cw  = w;
    ch  = h;
    cps = yps;
    cls = yls;

    // Chroma subsampling and the divisibility rule that goes with it.
    case (f)
      F_UYVY, F_YUY2, F_YVYU, F_HDYC: begin
        if (w % 2 != 0) ok = 1'b0;
        cw  = w / 2;
        cps = yps * 2;
      end
      F_YV12, F_IYUV, F_I420: begin
        if (w % 2 != 0 || h % 2 != 0) ok = 1'b0;
        cw  = w / 2;
        ch  = h / 2;
        cls = yls / 2;
      end
      F_IF09, F_YVU9: begin
        if (w % 4 != 0 || h % 4 != 0) ok = 1'b0;
        cw  = w / 4;
        ch  = h / 4;
        cls = yls / 4;
      end
      F_Y42B, F_YV16: begin
        if (w % 2 != 0) ok = 1'b0;
        cw  = w / 2;
        cls = yls / 2;
      end
      F_Y41B: begin
        if (w % 4 != 0) ok = 1'b0;
        cw  = w / 4;
        cls = yls / 4;
      end
      default: ;
    endcase

    // Packed formats place the samples inside a macropixel; planar ones put
    // the chroma planes after the luma plane, in the order of the FOURCC.
    plane  = yls * h;
    cplane = cls * ch;
    yo = 0;
    uo = 0;
    vo = 0;
    case (f)
      F_UYVY, F_HDYC: begin
        yo = 1;
        vo = 2;
      end
      F_YUY2: begin
        uo = 1;
        vo = 3;
      end
      F_YVYU: begin
        uo = 3;
        vo = 1;
      end
      F_IYUV, F_Y42B, F_I420, F_Y41B: begin
        uo = plane;
        vo = plane + cplane;
      end
      default: begin
        vo = plane;
        uo = plane + cplane;
      end
    endcase

    if (ok) begin
      lo.layout_valid        = 1'b1;
      lo.luma_pixel_stride   = yps[1:0];
      lo.luma_line_stride    = yls[13:0];
      lo.chroma_width        = cw[DIM_W-1:0];
      lo.chroma_height       = ch[DIM_W-1:0];
      lo.chroma_pixel_stride = cps[2:0];
      lo.chroma_line_stride  = cls[13:0];
      lo.luma_offset         = yo[0];
      lo.cb_offset           = uo[25:0];
      lo.cr_offset           = vo[25:0];
    end
    return lo;
  endfunction

  // Prints one line per mismatch and keeps the tally.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH result %0d: %s", $realtime, layouts_checked, what);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // Queues one request. The sender idles now and then before a request,
  // except inside the busy window and over the tail of the run.
  task automatic queue_request(input int w, input int h, input int f);
    req_beat_t b;
    bit        steady;
    steady = (beats_queued >= BUSY_FIRST && beats_queued < BUSY_LAST) ||
             (beats_queued >= TOTAL_BEATS - TAIL_BEATS);
    b.req.width  = w[DIM_W-1:0];
    b.req.height = h[DIM_W-1:0];
    b.req.format = f[3:0];
    b.gap        = (!steady && $urandom_range(0, 4) == 0) ?
                   4'($urandom_range(1, 15)) : 4'd0;
    layout_requests.push_back(b);
    beats_queued++;
  endtask

  // Request driver. A new beat is presented only once the current one has
  // been taken, and its idle gap is served first, one cycle at a time.
  logic [3:0] gap_left;
  bit         gap_served;

  always @(posedge clk) begin
    req_beat_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left   = '0;
      gap_served = 1'b0;
    end else begin
      // The payload still on the channel is the one that was just accepted.
      if (req_ch.valid && req_ch.ready)
        expected_layouts.push_back(predict_layout({req_ch.width, req_ch.height,
                                                   req_ch.format}));
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (layout_requests.size() != 0) begin
          if (!gap_served && layout_requests[0].gap != 0) begin
            gap_left   = layout_requests[0].gap - 4'd1;
            gap_served = 1'b1;
            req_ch.valid <= 1'b0;
          end else begin
            nxt        = layout_requests.pop_front();
            gap_served = 1'b0;
            req_ch.valid  <= 1'b1;
            req_ch.width  <= nxt.req.width;
            req_ch.height <= nxt.req.height;
            req_ch.format <= nxt.req.format;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver. Every accepted beat is checked against the
  // oldest prediction. Ready drops in short random bursts, stays high in a
  // steady window and over the tail, and drops once for a long hold-off
  // while the sender keeps pushing, so the pipeline fills and stalls.
  int  stall_left;
  int  hold_left;
  bit  hold_done;

  always @(posedge clk) begin
    layout_t want;
    bit      steady;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_layouts.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = expected_layouts.pop_front();
          check_field("layout_valid", rsp_ch.layout_valid, want.layout_valid);
          check_field("frame_bytes", rsp_ch.frame_bytes, want.frame_bytes);
          check_field("luma_pixel_stride", rsp_ch.luma_pixel_stride,
                      want.luma_pixel_stride);
          check_field("luma_line_stride", rsp_ch.luma_line_stride,
                      want.luma_line_stride);
          check_field("chroma_width", rsp_ch.chroma_width, want.chroma_width);
          check_field("chroma_height", rsp_ch.chroma_height, want.chroma_height);
          check_field("chroma_pixel_stride", rsp_ch.chroma_pixel_stride,
                      want.chroma_pixel_stride);
          check_field("chroma_line_stride", rsp_ch.chroma_line_stride,
                      want.chroma_line_stride);
          check_field("luma_offset", rsp_ch.luma_offset, want.luma_offset);
          check_field("cb_offset", rsp_ch.cb_offset, want.cb_offset);
          check_field("cr_offset", rsp_ch.cr_offset, want.cr_offset);
        end
        layouts_checked++;
      end

      steady = (layouts_checked >= STEADY_FIRST && layouts_checked < STEADY_LAST) ||
               (layouts_checked >= TOTAL_BEATS - TAIL_BEATS);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && layouts_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int pick;
    int w, h, f;

    req_ch.valid  = 1'b0;
    req_ch.width  = '0;
    req_ch.height = '0;
    req_ch.format = '0;
    rsp_ch.ready  = 1'b0;

    // Every code, known and unknown, at the largest legal frame: this also
    // gives the biggest sizes and offsets each format can reach.
    for (int code = 0; code < 16; code++) queue_request(MAX_DIM, MAX_DIM, code);
    // Zero dimensions, all-ones fields and oversized widths and heights.
    queue_request(0, 0, F_YV12);
    queue_request(8191, 8191, 15);
    queue_request(MAX_DIM + 1, 2, F_UYVY);
    queue_request(2, MAX_DIM + 1, F_YUY2);
    // Divisibility rules broken in one dimension or in both.
    queue_request(1, 1, F_I420);
    queue_request(2, 3, F_YV12);
    queue_request(6, 4, F_IF09);
    queue_request(4, 6, F_YVU9);
    queue_request(6, 3, F_Y41B);
    queue_request(3, 2, F_HDYC);

    // Random part: mostly well-formed frames of small size with any known
    // code, plus arbitrary legal sizes, tiny sizes that hit the divisibility
    // rules, and raw 13-bit values that reach the oversized case.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        w = 4 * $urandom_range(1, 32);
        h = 4 * $urandom_range(1, 32);
        f = $urandom_range(0, F_HDYC);
      end else if (pick < 60) begin
        w = 4 * $urandom_range(1, MAX_DIM / 4);
        h = 4 * $urandom_range(1, MAX_DIM / 4);
        f = $urandom_range(0, F_HDYC);
      end else if (pick < 78) begin
        w = $urandom_range(0, MAX_DIM);
        h = $urandom_range(0, MAX_DIM);
        f = $urandom_range(0, 15);
      end else if (pick < 90) begin
        w = $urandom_range(0, 9);
        h = $urandom_range(0, 9);
        f = $urandom_range(0, 15);
      end else begin
        w = $urandom_range(0, 8191);
        h = $urandom_range(0, 8191);
        f = $urandom_range(0, 15);
      end
      queue_request(w, h, f);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait until the last request has been taken, then until every
    // predicted result has come back, then a little longer in case the
    // block emits anything extra.
    do @(posedge clk); while (layout_requests.size() != 0 || req_ch.valid);
    while (expected_layouts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("yuv_plane_layout_test: done, clean");
    end else begin
      $display("yuv_plane_layout_test: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, which is well under a
  // millisecond even with every gap, stall and the long hold-off.
  initial begin
    #5_000_000;
    $display("yuv_plane_layout_test: done, errors");
    $finish;
  end

endmodule

### files.f
src/yuvpl_pkg.sv
src/yuvpl_if.sv
src/yuvpl_decode.sv
src/yuvpl_mult.sv
src/yuvpl_sum.sv
src/yuv_plane_layout.sv
tb/yuv_plane_layout_test.sv
